FILE: hw/rtl/lcr_pkg.sv
package lcr_pkg;

	localparam int DATA_BITS_DEF = 24;

	localparam int TICK_W  = 16;
	localparam int OFS_W   = 24;
	localparam int RAW_W   = 24;
	localparam int SCL_W   = 12;
	localparam int SUM_W   = 34;
	localparam int ADDR_W  = 4;
	localparam int PDATA_W = 32;

	// divide by 20000 as (mag >> 5) / 625, the latter by reciprocal
	localparam int M_LSB       = 5;
	localparam int M_W         = 21;
	localparam int RECIP_W     = 22;
	localparam int RECIP_SHIFT = 31;
	localparam int Q_W         = 11;
	localparam int PROD_W      = M_W + RECIP_W;

	localparam logic [RECIP_W-1:0] RECIP   = RECIP_W'(3435974);
	localparam logic [SUM_W-1:0]   SAT_MAG = SUM_W'(40960000);

	localparam logic signed [SUM_W-1:0] RAW_MAX = SUM_W'(8388607);
	localparam logic signed [SUM_W-1:0] RAW_MIN = SUM_W'(-8388608);
	localparam logic signed [SCL_W-1:0] SCL_MAX = SCL_W'(2047);
	localparam logic signed [SCL_W-1:0] SCL_MIN = SCL_W'(-2048);

	localparam logic [TICK_W-1:0]       HALF_RST = TICK_W'(1);
	localparam logic [TICK_W-1:0]       GAP_RST  = TICK_W'(100);
	localparam logic signed [OFS_W-1:0] OFS_RST  = OFS_W'(200000);

	localparam logic [1:0] REG_HALF = 2'd0;
	localparam logic [1:0] REG_GAP  = 2'd1;
	localparam logic [1:0] REG_OFS  = 2'd2;

	typedef enum logic [3:0] {
		PH_WAIT = 4'b0001,
		PH_HIGH = 4'b0010,
		PH_LOW  = 4'b0100,
		PH_GAP  = 4'b1000
	} phase_t;

	typedef struct packed {
		logic clock_line;
		logic reading_valid;
	} ctl_t;

endpackage

FILE: hw/rtl/lcr_ctrl.sv
module lcr_ctrl #(
	parameter int DATA_BITS = lcr_pkg::DATA_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        step,
	input  logic                        data_line,
	input  logic [lcr_pkg::TICK_W-1:0]  half_ticks,
	input  logic [lcr_pkg::TICK_W-1:0]  gap_ticks,
	output lcr_pkg::ctl_t               res,
	output logic [DATA_BITS-1:0]        code
);
	import lcr_pkg::*;

	localparam int BC_W = $clog2(DATA_BITS + 2);

	phase_t              phase_q, phase_d;
	logic [BC_W-1:0]     bit_q, bit_d;
	logic [TICK_W-1:0]   tick_q, tick_d;
	logic [TICK_W:0]     tick_inc;
	logic [DATA_BITS-1:0] shift_q, shift_d;

	assign tick_inc = {1'b0, tick_q} + (TICK_W+1)'(1);

	always_comb begin
		phase_d = phase_q;
		bit_d = bit_q;
		tick_d = tick_q;
		shift_d = shift_q;
		res.clock_line = 1'b0;
		res.reading_valid = 1'b0;
		unique case (phase_q)
			PH_WAIT: begin
				if (!data_line) begin
					phase_d = PH_HIGH;
					tick_d = TICK_W'(1);
					bit_d = '0;
					shift_d = '0;
					res.clock_line = 1'b1;
				end
			end
			PH_HIGH: begin
				if (tick_q >= half_ticks) begin
					if (bit_q < BC_W'(DATA_BITS))
						shift_d = {shift_q[DATA_BITS-2:0], data_line};
					bit_d = bit_q + BC_W'(1);
					phase_d = PH_LOW;
					tick_d = TICK_W'(1);
				end else begin
					tick_d = tick_inc[TICK_W-1:0];
					res.clock_line = 1'b1;
				end
			end
			PH_LOW: begin
				if (tick_q >= half_ticks) begin
					if (bit_q <= BC_W'(DATA_BITS)) begin
						phase_d = PH_HIGH;
						tick_d = TICK_W'(1);
						res.clock_line = 1'b1;
					end else begin
						// gain pulse done: word complete
						res.reading_valid = 1'b1;
						tick_d = '0;
						phase_d = (gap_ticks == '0) ? PH_WAIT : PH_GAP;
					end
				end else begin
					tick_d = tick_inc[TICK_W-1:0];
				end
			end
			PH_GAP: begin
				if (tick_inc >= {1'b0, gap_ticks}) begin
					phase_d = PH_WAIT;
					tick_d = '0;
				end else begin
					tick_d = tick_inc[TICK_W-1:0];
				end
			end
			default: begin
				phase_d = PH_WAIT;
				tick_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_WAIT;
			bit_q <= '0;
			tick_q <= '0;
			shift_q <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			bit_q <= bit_d;
			tick_q <= tick_d;
			shift_q <= shift_d;
		end
	end

	assign code = shift_q;

	a_bit_range: assert property (@(posedge clk) disable iff (!arst_n)
		bit_q <= BC_W'(DATA_BITS + 1))
		else $error("bit count beyond gain pulse");

	a_gap_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_GAP |-> bit_q == BC_W'(DATA_BITS + 1))
		else $error("gap entered before all pulses");

	a_valid_from_low: assert property (@(posedge clk) disable iff (!arst_n)
		res.reading_valid |-> phase_q == PH_LOW && !res.clock_line)
		else $error("reading finished outside low phase");

endmodule

FILE: hw/rtl/lcr_scale.sv
module lcr_scale (
	input  logic                               clk,
	input  logic                               en,
	input  logic signed [lcr_pkg::SUM_W-1:0]   sum,
	output logic signed [lcr_pkg::SCL_W-1:0]   scaled
);
	import lcr_pkg::*;

	logic              neg;
	logic [SUM_W-1:0]  mag;
	logic              neg_s2, sat_s2;
	logic [M_W-1:0]    m_s2;
	logic              neg_s3, sat_s3;
	logic [PROD_W-1:0] prod_s3;
	logic [SCL_W-1:0]  q_ext;

	assign neg = sum[SUM_W-1];
	assign mag = neg ? SUM_W'(-sum) : SUM_W'(sum);

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s2 <= neg;
			sat_s2 <= (mag >= SAT_MAG);
			m_s2 <= mag[M_LSB+M_W-1:M_LSB];
			neg_s3 <= neg_s2;
			sat_s3 <= sat_s2;
			prod_s3 <= PROD_W'(m_s2) * PROD_W'(RECIP);
		end
	end

	assign q_ext = {1'b0, prod_s3[RECIP_SHIFT+Q_W-1:RECIP_SHIFT]};

	always_comb begin
		priority if (sat_s3)
			scaled = neg_s3 ? SCL_MIN : SCL_MAX;
		else if (neg_s3)
			scaled = -$signed(q_ext);
		else
			scaled = $signed(q_ext);
	end

endmodule

FILE: hw/rtl/load_cell_adc_serial_reader_unit.sv
// Pipeline: a tick word accepted at the input passes the registered stages sum, magnitude,
//   reciprocal multiply and output, and its result word is then taken from the output register.
// Throughput: one tick word per cycle; the whole pipe stalls only while the output register
//   holds a word and m_tready is low.
// Reset: arst_n asynchronous, active low; clears pipe valids, control state and the
//   held raw and scaled values, and loads the registers with 1, 100 and 200000.
module load_cell_adc_serial_reader_unit #(
	parameter int DATA_BITS = lcr_pkg::DATA_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,  // [0] data_line
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [39:0]                   m_tdata,  // [0] clock_line, [24:1] raw_code,
	                                                // [36:25] scaled_value
	output logic                          m_tuser,  // [0] reading_valid
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [lcr_pkg::ADDR_W-1:0]    paddr,
	input  logic [lcr_pkg::PDATA_W-1:0]   pwdata,
	output logic [lcr_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready
);
	import lcr_pkg::*;

	logic [TICK_W-1:0]       cfg_half_q, cfg_gap_q;
	logic signed [OFS_W-1:0] cfg_ofs_q;

	logic                    en, accept;
	ctl_t                    ctl;
	logic [DATA_BITS-1:0]    code;
	logic signed [SUM_W-1:0] raw_ext, sum, raw_sat;

	logic                    vld_s1, vld_s2, vld_s3, out_vld_q;
	ctl_t                    ctl_s1, ctl_s2, ctl_s3;
	logic signed [RAW_W-1:0] raw_s1, raw_s2, raw_s3;
	logic signed [SUM_W-1:0] sum_s1;
	logic signed [SCL_W-1:0] scaled;

	logic                    clk_line_q, rv_q;
	logic signed [RAW_W-1:0] raw_q;
	logic signed [SCL_W-1:0] scl_q;

	// configuration
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_half_q <= HALF_RST;
			cfg_gap_q <= GAP_RST;
			cfg_ofs_q <= OFS_RST;
		end else if (psel && penable && pwrite && pready) begin
			unique case (paddr[3:2])
				REG_HALF: cfg_half_q <= pwdata[TICK_W-1:0];
				REG_GAP:  cfg_gap_q <= pwdata[TICK_W-1:0];
				REG_OFS:  cfg_ofs_q <= pwdata[OFS_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_HALF: prdata = PDATA_W'(cfg_half_q);
			REG_GAP:  prdata = PDATA_W'(cfg_gap_q);
			REG_OFS:  prdata = {{(PDATA_W-OFS_W){1'b0}}, cfg_ofs_q};
			default:  prdata = '0;
		endcase
	end

	// pipe advances whenever the output register is free or being drained
	assign en = !out_vld_q || m_tready;
	assign s_tready = en;
	assign accept = s_tvalid && en;

	lcr_ctrl #(
		.DATA_BITS(DATA_BITS)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.step(accept),
		.data_line(s_tdata[0]),
		.half_ticks(cfg_half_q),
		.gap_ticks(cfg_gap_q),
		.res(ctl),
		.code(code)
	);

	assign raw_ext = SUM_W'($signed(code));
	assign sum = raw_ext + SUM_W'(cfg_ofs_q);

	always_comb begin
		priority if (raw_ext > RAW_MAX)
			raw_sat = RAW_MAX;
		else if (raw_ext < RAW_MIN)
			raw_sat = RAW_MIN;
		else
			raw_sat = raw_ext;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			out_vld_q <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_tvalid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			out_vld_q <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s1 <= ctl;
			raw_s1 <= raw_sat[RAW_W-1:0];
			sum_s1 <= sum;
			ctl_s2 <= ctl_s1;
			raw_s2 <= raw_s1;
			ctl_s3 <= ctl_s2;
			raw_s3 <= raw_s2;
		end
	end

	lcr_scale u_scale (
		.clk(clk),
		.en(en),
		.sum(sum_s1),
		.scaled(scaled)
	);

	// output word; raw and scaled hold the last finished reading
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clk_line_q <= 1'b0;
			rv_q <= 1'b0;
			raw_q <= '0;
			scl_q <= '0;
		end else if (en && vld_s3) begin
			clk_line_q <= ctl_s3.clock_line;
			rv_q <= ctl_s3.reading_valid;
			if (ctl_s3.reading_valid) begin
				raw_q <= raw_s3;
				scl_q <= scaled;
			end
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata = {3'b000, scl_q, raw_q, clk_line_q};
	assign m_tuser = rv_q;

	a_read_clock_low: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> !m_tdata[0])
		else $error("reading word with clock line high");

	a_hold_while_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result word changed while stalled");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input blocked with output free");

endmodule

FILE: test/load_cell_adc_serial_reader_unit_tb.sv
`timescale 1ns / 1ps

module load_cell_adc_serial_reader_unit_tb;
	import lcr_pkg::*;

	typedef struct packed {
		logic               clock_line;
		logic               reading_valid;
		logic signed [23:0] raw_code;
		logic signed [11:0] scaled_value;
	} tick_result_t;

	class reading_scoreboard;
		logic [15:0]        half_ticks;
		logic [15:0]        gap_ticks;
		logic signed [23:0] zero_ofs;
		phase_t             phase;
		int unsigned        bit_cnt;
		int unsigned        tick_cnt;
		logic [23:0]        shift;
		logic signed [23:0] last_raw;
		logic signed [11:0] last_scl;
		tick_result_t       due[$];
		int                 errors;
		int                 readings;

		function new();
			half_ticks = HALF_RST;
			gap_ticks  = GAP_RST;
			zero_ofs   = OFS_RST;
			phase      = PH_WAIT;
			bit_cnt    = 0;
			tick_cnt   = 0;
			shift      = '0;
			last_raw   = '0;
			last_scl   = '0;
			errors     = 0;
			readings   = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [31:0] value);
			case (idx)
				REG_HALF: half_ticks = value[15:0];
				REG_GAP:  gap_ticks  = value[15:0];
				REG_OFS:  zero_ofs   = value[23:0];
				default: ;
			endcase
		endfunction

		// one tick word in, one result word predicted
		function void note_tick(bit line);
			tick_result_t r;
			longint       sum;
			longint       q;
			r = '0;
			case (phase)
				PH_WAIT: begin
					if (!line) begin
						phase        = PH_HIGH;
						tick_cnt     = 1;
						bit_cnt      = 0;
						shift        = '0;
						r.clock_line = 1'b1;
					end
				end
				PH_HIGH: begin
					if (tick_cnt >= half_ticks) begin
						if (bit_cnt < DATA_BITS_DEF)
							shift = {shift[22:0], line};
						bit_cnt++;
						phase    = PH_LOW;
						tick_cnt = 1;
					end else begin
						tick_cnt++;
						r.clock_line = 1'b1;
					end
				end
				PH_LOW: begin
					if (tick_cnt >= half_ticks) begin
						if (bit_cnt <= DATA_BITS_DEF) begin
							phase        = PH_HIGH;
							tick_cnt     = 1;
							r.clock_line = 1'b1;
						end else begin
							// gain pulse done: sign-extend, offset, /10000 then /2
							sum = longint'($signed(shift)) + longint'(zero_ofs);
							q   = (sum / 10000) / 2;
							if (q > 2047)
								q = 2047;
							else if (q < -2048)
								q = -2048;
							last_raw        = shift;
							last_scl        = q[11:0];
							r.reading_valid = 1'b1;
							readings++;
							tick_cnt = 0;
							phase    = (gap_ticks == 0) ? PH_WAIT : PH_GAP;
						end
					end else begin
						tick_cnt++;
					end
				end
				PH_GAP: begin
					tick_cnt++;
					if (tick_cnt >= gap_ticks) begin
						phase    = PH_WAIT;
						tick_cnt = 0;
					end
				end
				default: begin
					phase    = PH_WAIT;
					tick_cnt = 0;
				end
			endcase
			r.raw_code     = last_raw;
			r.scaled_value = last_scl;
			due.push_back(r);
		endfunction

		function void mismatch(string field, longint want_v, longint got_v);
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want_v, got_v);
			errors++;
		endfunction

		function void check_word(logic [39:0] data, logic user);
			tick_result_t want;
			if (due.size() == 0) begin
				$display("%0t: result word with nothing expected, actual %h/%b",
					$time, data, user);
				errors++;
				return;
			end
			want = due.pop_front();
			if (data[0] !== want.clock_line)
				mismatch("clock_line", want.clock_line, data[0]);
			if (user !== want.reading_valid)
				mismatch("reading_valid", want.reading_valid, user);
			if (data[24:1] !== want.raw_code)
				mismatch("raw_code", want.raw_code, $signed(data[24:1]));
			if (data[36:25] !== want.scaled_value)
				mismatch("scaled_value", want.scaled_value, $signed(data[36:25]));
		endfunction
	endclass

	localparam logic [1:0] REG_SPARE = 2'd3;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // [0] data_line
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;   // [0] clock_line, [24:1] raw_code, [36:25] scaled_value
	logic        m_tuser;   // [0] reading_valid
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	reading_scoreboard sb;
	logic [23:0]       code_now;
	bit                no_idle;

	load_cell_adc_serial_reader_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready)
				sb.check_word(m_tdata, m_tuser);
			m_tready <= no_idle || ($urandom_range(0, 99) >= 10);
		end
	end

	function automatic logic [23:0] rand_code();
		case ($urandom_range(0, 7))
			0: return 24'h000000;
			1: return 24'hFFFFFF;
			2: return 24'h800000;
			3: return 24'h7FFFFF;
			default: return 24'($urandom());
		endcase
	endfunction

	function automatic logic [31:0] rand_offset();
		case ($urandom_range(0, 5))
			0: return 32'h007FFFFF;
			1: return 32'h00800000;
			2: return 32'd0;
			default: return 32'($urandom_range(0, 24'hFFFFFF));
		endcase
	endfunction

	// drive the code's bit on the tick where the high phase ends, low in the wait phase only to start, noise elsewhere
	function automatic bit next_line(bit start_now);
		if (sb.phase == PH_WAIT)
			return !start_now;
		if (sb.phase == PH_HIGH && sb.tick_cnt >= sb.half_ticks && sb.bit_cnt < DATA_BITS_DEF)
			return code_now[DATA_BITS_DEF - 1 - sb.bit_cnt];
		return 1'($urandom_range(0, 1));
	endfunction

	task automatic send_tick(bit line);
		if (!no_idle && $urandom_range(0, 99) < 5) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {7'b0, line};
		do @(posedge clk); while (!s_tready);
		sb.note_tick(line);
	endtask

	task automatic read_code(logic [23:0] code);
		int target;
		target   = sb.readings + 1;
		code_now = code;
		while (sb.readings < target)
			send_tick(next_line(1'b1));
	endtask

	task automatic run_ticks(int n);
		bit go;
		repeat (n) begin
			go = 1'b0;
			if (sb.phase == PH_WAIT) begin
				go = $urandom_range(0, 99) < 25;
				if (go)
					code_now = rand_code();
			end
			send_tick(next_line(go));
		end
	endtask

	// hold off input until every pending word is back
	task automatic settle();
		s_tvalid <= 1'b0;
		while (sb.due.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_reg(idx, value);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		#3_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		logic [15:0] half_set[10] = '{16'd1, 16'd1, 16'd2, 16'd3, 16'd0,
			16'd1, 16'd4, 16'd1, 16'd2, 16'd1};
		sb       = new();
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		code_now = '0;
		no_idle  = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings first, then extreme offsets against extreme codes
		read_code(24'h123456);
		run_ticks(30);
		settle();
		write_reg(REG_HALF, 32'd0);
		write_reg(REG_GAP, 32'd0);
		write_reg(REG_OFS, 32'h007FFFFF);
		write_reg(REG_SPARE, 32'hFFFFFFFF);
		read_code(24'h7FFFFF);
		read_code(24'h800000);
		settle();
		write_reg(REG_OFS, 32'h00800000);
		read_code(24'h800000);
		read_code(24'hFFFFFF);
		read_code(24'h000000);
		settle();

		// readings run on across settings changes
		for (int p = 0; p < 10; p++) begin
			no_idle = (p == 4);
			write_reg(REG_HALF, 32'(half_set[p]));
			write_reg(REG_GAP, ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom_range(1, 6));
			write_reg(REG_OFS, rand_offset());
			run_ticks(no_idle ? 100 : 20);
			settle();
		end
		no_idle = 1'b0;

		// widest half period: reading sits in a high phase, then the length is cut short
		write_reg(REG_HALF, 32'h0000FFFF);
		run_ticks(40);
		settle();
		write_reg(REG_HALF, 32'd1);
		read_code(rand_code());
		settle();

		// leave the short gap, then widest gap, cut short mid-gap
		run_ticks(8);
		settle();
		write_reg(REG_GAP, 32'h0000FFFF);
		read_code(24'h5A5A5A);
		run_ticks(30);
		settle();
		write_reg(REG_GAP, 32'd3);
		run_ticks(40);
		settle();

		repeat (10) @(posedge clk);
		if (sb.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
